@@ design/lbbs_pkg.sv @@
package lbbs_pkg;

    localparam int COORD_W    = 14;
    localparam int BOX_W      = 15;
    localparam int IDX_OUT_W  = 5;
    localparam int BASE_W     = 16;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 104;

    localparam logic [BOX_W-1:0]  BOX_INIT   = 15'd32767;
    localparam logic [BASE_W-1:0] BASE_EMPTY = 16'hFFFF;

    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    typedef logic [COORD_W-1:0]    t_coord;
    typedef logic [BOX_W-1:0]      t_box;
    typedef logic [IN_DATA_W-1:0]  t_in_data;
    typedef logic [OUT_DATA_W-1:0] t_out_data;

endpackage

@@ design/label_box_baseline_sorter.sv @@
// Label box and baseline sorter.
// Add transaction: accepted while idle, no result.
// Finish transaction: accepted, then a serial restoring divide of the sum of bottoms by the
// count for the baseline, then per result a scan over the x memory and an output step.
// An empty label skips divide and scan. One transaction at a time; the scan covers the stored symbols.
// Reset (synchronous, active low) clears the label state; x memory is not cleared.
module label_box_baseline_sorter #(
    parameter int MAX_SYMBOLS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // tdata: sym_x, sym_y, sym_width, sym_height
    input  lbbs_pkg::t_in_data        i_s_axis_tdata,
    // tuser: kind
    input  logic                      i_s_axis_tuser,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // tdata: symbol_index, sym_x_out, box_min_x, box_min_y, box_max_x,
    //        box_max_y, baseline, multiline, empty_label, overflow, zero pad
    output lbbs_pkg::t_out_data       o_m_axis_tdata,
    output logic                      o_m_axis_tlast
);
    import lbbs_pkg::*;

    localparam int CNT_W  = $clog2(MAX_SYMBOLS + 1);
    localparam int IDX_W  = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int SUM_W  = $clog2(MAX_SYMBOLS * 32767 + 1);
    localparam int STEP_W = $clog2(SUM_W + 1);
    localparam int KEY_W  = COORD_W + IDX_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_PUT  = 2'd3;

    // x memory
    t_coord             x_mem [MAX_SYMBOLS];
    t_coord             r_rd_data;

    logic [1:0]         r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [SUM_W-1:0]   r_sum;
    t_box               r_left_min, r_top_min, r_right_max, r_bottom_max;
    t_box               r_least_bottom, r_greatest_top;
    logic               r_multi, r_drop;

    logic [SUM_W-1:0]   r_div_acc;
    logic [CNT_W-1:0]   r_div_rem;
    logic [STEP_W-1:0]  r_div_step;
    logic [BASE_W-1:0]  r_base;

    logic [CNT_W-1:0]   r_rd_ptr;
    logic               r_cmp_valid;
    logic [IDX_W-1:0]   r_cmp_idx;
    logic               r_best_found;
    logic [KEY_W-1:0]   r_best_key;
    logic [KEY_W-1:0]   r_prev_key;
    logic [CNT_W-1:0]   r_out_cnt;
    logic               r_empty;

    logic               r_out_valid;
    t_out_data          r_out_data;
    logic               r_out_last;

    t_coord             in_x, in_y, in_w, in_h;
    t_box               in_right, in_bottom, n_lb, n_gt;
    logic               in_fire, out_free, is_last;
    logic [CNT_W:0]     div_trial;
    logic [KEY_W-1:0]   cmp_key;
    logic               take;

    assign in_x      = i_s_axis_tdata[13:0];
    assign in_y      = i_s_axis_tdata[27:14];
    assign in_w      = i_s_axis_tdata[41:28];
    assign in_h      = i_s_axis_tdata[55:42];
    assign in_right  = {1'b0, in_x} + {1'b0, in_w};
    assign in_bottom = {1'b0, in_y} + {1'b0, in_h};
    assign n_lb      = (in_bottom < r_least_bottom) ? in_bottom : r_least_bottom;
    assign n_gt      = ({1'b0, in_y} > r_greatest_top) ? {1'b0, in_y} : r_greatest_top;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign is_last         = r_empty || (r_out_cnt == r_cnt - CNT_W'(1));

    assign div_trial = {r_div_rem, r_div_acc[SUM_W-1]};
    assign cmp_key   = {r_rd_data, r_cmp_idx};
    assign take      = r_cmp_valid && ((r_out_cnt == '0) || (cmp_key > r_prev_key))
                       && (!r_best_found || (cmp_key < r_best_key));

    // write on add, registered read for the scan
    always_ff @(posedge i_clk) begin
        if (in_fire && i_s_axis_tuser == KIND_ADD && r_cnt < CNT_W'(MAX_SYMBOLS))
            x_mem[r_cnt[IDX_W-1:0]] <= in_x;
        r_rd_data <= x_mem[r_rd_ptr[IDX_W-1:0]];
    end

    // sequencer and label state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_cnt          <= '0;
            r_sum          <= '0;
            r_left_min     <= BOX_INIT;
            r_top_min      <= BOX_INIT;
            r_right_max    <= '0;
            r_bottom_max   <= '0;
            r_least_bottom <= BOX_INIT;
            r_greatest_top <= '0;
            r_multi        <= 1'b0;
            r_drop         <= 1'b0;
            r_out_valid    <= 1'b0;
            r_cmp_valid    <= 1'b0;
            r_best_found   <= 1'b0;
            r_out_cnt      <= '0;
            r_empty        <= 1'b0;
            r_rd_ptr       <= '0;
        end else begin
            // hold a result until the sink takes it
            if (r_state == ST_PUT && out_free)
                r_out_valid <= 1'b1;
            else if (i_m_axis_tready)
                r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (in_fire && i_s_axis_tuser == KIND_ADD) begin
                        if (r_cnt >= CNT_W'(MAX_SYMBOLS)) begin
                            r_drop <= 1'b1;
                        end else begin
                            r_cnt          <= r_cnt + CNT_W'(1);
                            r_sum          <= r_sum + SUM_W'(in_bottom);
                            if ({1'b0, in_x} < r_left_min) r_left_min <= {1'b0, in_x};
                            if ({1'b0, in_y} < r_top_min) r_top_min <= {1'b0, in_y};
                            if (in_right > r_right_max) r_right_max <= in_right;
                            if (in_bottom > r_bottom_max) r_bottom_max <= in_bottom;
                            r_least_bottom <= n_lb;
                            r_greatest_top <= n_gt;
                            if ({1'b0, in_y} >= n_lb || in_bottom <= n_gt)
                                r_multi <= 1'b1;
                        end
                    end else if (in_fire) begin
                        r_out_cnt <= '0;
                        if (r_cnt == '0) begin
                            r_empty <= 1'b1;
                            r_state <= ST_PUT;
                        end else begin
                            r_empty    <= 1'b0;
                            r_div_acc  <= r_sum;
                            r_div_rem  <= '0;
                            r_div_step <= '0;
                            r_state    <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    // one restoring step per cycle
                    if (div_trial >= {1'b0, r_cnt}) begin
                        r_div_rem <= CNT_W'(div_trial - {1'b0, r_cnt});
                        r_div_acc <= {r_div_acc[SUM_W-2:0], 1'b1};
                    end else begin
                        r_div_rem <= div_trial[CNT_W-1:0];
                        r_div_acc <= {r_div_acc[SUM_W-2:0], 1'b0};
                    end
                    r_div_step <= r_div_step + STEP_W'(1);
                    if (r_div_step == STEP_W'(SUM_W - 1)) begin
                        r_rd_ptr     <= '0;
                        r_cmp_valid  <= 1'b0;
                        r_best_found <= 1'b0;
                        r_state      <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // find the smallest key above the one emitted last (any key for the first result)
                    if (r_div_step == STEP_W'(SUM_W)) begin
                        r_base     <= BASE_W'(r_div_acc);
                        r_div_step <= '0;
                    end
                    if (r_rd_ptr < r_cnt) begin
                        r_cmp_valid <= 1'b1;
                        r_cmp_idx   <= r_rd_ptr[IDX_W-1:0];
                        r_rd_ptr    <= r_rd_ptr + CNT_W'(1);
                    end else begin
                        r_cmp_valid <= 1'b0;
                    end
                    if (take) begin
                        r_best_found <= 1'b1;
                        r_best_key   <= cmp_key;
                    end
                    if (!r_cmp_valid && r_rd_ptr == r_cnt && r_rd_ptr != '0)
                        r_state <= ST_PUT;
                end
                ST_PUT: begin
                    if (out_free) begin
                        r_out_last  <= is_last;
                        r_out_data  <= {6'b0, r_drop, r_empty, r_multi,
                                        (r_empty ? BASE_EMPTY : r_base),
                                        r_bottom_max, r_right_max, r_top_min, r_left_min,
                                        (r_empty ? '0 : r_best_key[KEY_W-1:IDX_W]),
                                        (r_empty ? '0 :
                                         IDX_OUT_W'(r_best_key[IDX_W-1:0]))};
                        r_prev_key  <= r_best_key;
                        if (is_last) begin
                            // drop the label and return to reset values
                            r_cnt          <= '0;
                            r_sum          <= '0;
                            r_left_min     <= BOX_INIT;
                            r_top_min      <= BOX_INIT;
                            r_right_max    <= '0;
                            r_bottom_max   <= '0;
                            r_least_bottom <= BOX_INIT;
                            r_greatest_top <= '0;
                            r_multi        <= 1'b0;
                            r_drop         <= 1'b0;
                            r_empty        <= 1'b0;
                            r_state        <= ST_IDLE;
                        end else begin
                            r_out_cnt    <= r_out_cnt + CNT_W'(1);
                            r_rd_ptr     <= '0;
                            r_cmp_valid  <= 1'b0;
                            r_best_found <= 1'b0;
                            r_state      <= ST_SCAN;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_SYMBOLS)) else $error("symbol count above capacity");
    a_put_has_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUT && !r_empty) |-> r_best_found)
        else $error("result without a selected symbol");
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_out_cnt < r_cnt))
        else $error("scan beyond stored symbols");
`endif

endmodule
